// ===== design/rdbs_pkg.sv =====
// shared types and constants of the reuse detector bypass replacement block
package rdbs_pkg;

	// default geometry
	localparam int CACHE_SETS     = 2048;
	localparam int CACHE_WAYS     = 16;
	localparam int TABLE_SET_BITS = 8;
	localparam int TABLE_WAYS     = 16;
	localparam int TABLE_TAG_BITS = 9;
	localparam int PC_INDEX_BITS  = 7;

	// field widths of the channels
	localparam int MODE_W  = 1;
	localparam int SET_W   = 11;
	localparam int WAY_W   = 5;
	localparam int LINE_W  = 19;
	localparam int PCLOW_W = 9;
	localparam int KIND_W  = 2;

	// table sectors and pc tracking
	localparam int SECTOR_BITS   = 2;
	localparam int SECTORS       = 4;
	localparam int PC_SHIFT      = 2;
	localparam int TRACK_BITS    = 2;

	// counters
	localparam int CTR_W         = 10;
	localparam int REUSE_SHIFT   = 6;
	localparam int MISS_W        = 3;
	localparam logic [CTR_W-1:0] REUSE_INIT   = 10'd3;
	localparam logic [CTR_W-1:0] NOREUSE_INIT = 10'd0;

	// rrpv values
	localparam logic [1:0] RRPV_MAX  = 2'd3;
	localparam logic [1:0] RRPV_FILL = 2'd2;
	localparam logic [1:0] RRPV_HIT  = 2'd0;

	localparam logic MODE_VICTIM = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD,
		KIND_RFO,
		KIND_PREFETCH,
		KIND_WRITEBACK
	} kind_t;

	// class of a request as seen by the back end
	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_PLAIN,
		OP_UPDATE,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [SET_W-1:0]   set_index;
		logic [WAY_W-1:0]   way;
		logic [LINE_W-1:0]  line_address;
		logic [PCLOW_W-1:0] pc_low;
		logic               hit;
	} cmd_t;

	typedef struct packed {
		logic [WAY_W-1:0] victim_way;
		logic             bypass;
		logic             table_hit;
	} rsp_t;

	typedef struct packed {
		logic [CTR_W-1:0] reuse;
		logic [CTR_W-1:0] noreuse;
	} ctr_t;

endpackage

// ===== design/rdbs_req_if.sv =====
// request channel interface
interface rdbs_req_if;
	logic                          valid;
	logic                          ready;
	logic [rdbs_pkg::MODE_W-1:0]   mode;
	logic [rdbs_pkg::SET_W-1:0]    set_index;
	logic [rdbs_pkg::WAY_W-1:0]    way;
	logic [rdbs_pkg::LINE_W-1:0]   line_address;
	logic [rdbs_pkg::PCLOW_W-1:0]  pc_low;
	logic [rdbs_pkg::KIND_W-1:0]   access_kind;
	logic                          hit;

	modport source (output valid, mode, set_index, way, line_address, pc_low, access_kind,
		hit, input ready);
	modport sink (input valid, mode, set_index, way, line_address, pc_low, access_kind,
		hit, output ready);
endinterface

// ===== design/rdbs_rsp_if.sv =====
// response channel interface
interface rdbs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rdbs_pkg::WAY_W-1:0]  victim_way;
	logic                        bypass;
	logic                        table_hit;

	modport source (output valid, victim_way, bypass, table_hit, input ready);
	modport sink (input valid, victim_way, bypass, table_hit, output ready);
endinterface

// ===== design/reuse_detector_bypass_srrip.sv =====
// top level of the reuse detector bypass replacement block with 2-bit srrip
//
//   channel | direction | contents
//   req     | in        | mode, set_index, way, line_address, pc_low, access_kind, hit
//   rsp     | out       | victim_way, bypass, table_hit
//
// one request is worked on at a time by the back end sequencer; a two entry
// queue in the front end keeps taking requests while the back end works, until it is full
// a lookup that hits in a tracked table set makes one pc reuse bump, and a miss
// makes one bump for each evicted sector (at most 4); each bump is a read
// then a write of the pc counter memory
// after reset a clearing pass over max(CACHE_SETS, table sets, pc entries)
// addresses (2048 by default) fills all memories; requests wait until it ends
// a stalled response holds in the output register and the next request
// starts only once that register is free
module reuse_detector_bypass_srrip #(
	parameter int CACHE_SETS     = rdbs_pkg::CACHE_SETS,
	parameter int CACHE_WAYS     = rdbs_pkg::CACHE_WAYS,
	parameter int TABLE_SET_BITS = rdbs_pkg::TABLE_SET_BITS,
	parameter int TABLE_WAYS     = rdbs_pkg::TABLE_WAYS,
	parameter int TABLE_TAG_BITS = rdbs_pkg::TABLE_TAG_BITS,
	parameter int PC_INDEX_BITS  = rdbs_pkg::PC_INDEX_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	rdbs_req_if.sink   req,
	rdbs_rsp_if.source rsp
);
	// queue between front and back
	logic           q_valid;
	logic           q_ready;
	rdbs_pkg::cmd_t q_cmd;
	// clearing pass finished
	logic           init_done;

	// decode and buffer
	rdbs_front #(
		.CACHE_WAYS(CACHE_WAYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.init_done (init_done),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd)
	);

	// table, counters and rrpv state
	rdbs_back #(
		.CACHE_SETS     (CACHE_SETS),
		.CACHE_WAYS     (CACHE_WAYS),
		.TABLE_SET_BITS (TABLE_SET_BITS),
		.TABLE_WAYS     (TABLE_WAYS),
		.TABLE_TAG_BITS (TABLE_TAG_BITS),
		.PC_INDEX_BITS  (PC_INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.init_done (init_done),
		.rsp       (rsp)
	);
endmodule

// ===== design/rdbs_ram.sv =====
// generic single write port ram with registered read
module rdbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/rdbs_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module rdbs_front #(
	parameter int CACHE_WAYS = rdbs_pkg::CACHE_WAYS
) (
	input  logic             clk,
	input  logic             arst_n,
	rdbs_req_if.sink         req,
	input  logic             init_done,
	output logic             q_valid,
	input  logic             q_ready,
	output rdbs_pkg::cmd_t   q_cmd
);
	rdbs_pkg::cmd_t cmd_in;
	rdbs_pkg::cmd_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	// classify
	always_comb begin
		cmd_in.set_index    = req.set_index;
		cmd_in.way          = req.way;
		cmd_in.line_address = req.line_address;
		cmd_in.pc_low       = req.pc_low;
		cmd_in.hit          = req.hit;
		if (req.mode == rdbs_pkg::MODE_UPDATE) begin
			if (req.access_kind != rdbs_pkg::KIND_WRITEBACK && 32'(req.way) < CACHE_WAYS) begin
				cmd_in.op = rdbs_pkg::OP_UPDATE;
			end else begin
				cmd_in.op = rdbs_pkg::OP_IGNORE;
			end
		end else if (req.access_kind == rdbs_pkg::KIND_WRITEBACK) begin
			cmd_in.op = rdbs_pkg::OP_PLAIN;
		end else begin
			cmd_in.op = rdbs_pkg::OP_LOOKUP;
		end
	end

	assign req.ready = init_done && (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_cmd     = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cmd_in;
		end
	end
endmodule

// ===== design/rdbs_back.sv =====
// back end: table lookup, pc counters, bypass decision and srrip state
module rdbs_back #(
	parameter int CACHE_SETS     = rdbs_pkg::CACHE_SETS,
	parameter int CACHE_WAYS     = rdbs_pkg::CACHE_WAYS,
	parameter int TABLE_SET_BITS = rdbs_pkg::TABLE_SET_BITS,
	parameter int TABLE_WAYS     = rdbs_pkg::TABLE_WAYS,
	parameter int TABLE_TAG_BITS = rdbs_pkg::TABLE_TAG_BITS,
	parameter int PC_INDEX_BITS  = rdbs_pkg::PC_INDEX_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  rdbs_pkg::cmd_t q_cmd,
	output logic           init_done,
	rdbs_rsp_if.source     rsp
);
	localparam int SET_W     = $clog2(CACHE_SETS);
	localparam int CWI       = $clog2(CACHE_WAYS);
	localparam int TSETS     = 1 << TABLE_SET_BITS;
	localparam int NPCS      = 1 << PC_INDEX_BITS;
	localparam int TWB       = $clog2(TABLE_WAYS);
	localparam int SPC_AW    = TABLE_SET_BITS - rdbs_pkg::TRACK_BITS;
	localparam int SPC_DEPTH = TSETS >> rdbs_pkg::TRACK_BITS;
	localparam int TAG_SHIFT = TABLE_SET_BITS + rdbs_pkg::SECTOR_BITS;
	localparam int SECS      = rdbs_pkg::SECTORS;
	localparam int CW        = rdbs_pkg::CTR_W;
	localparam int CLR_A     = (CACHE_SETS > TSETS) ? CACHE_SETS : TSETS;
	localparam int CLR_N     = (CLR_A > NPCS) ? CLR_A : NPCS;
	localparam int CLR_W     = $clog2(CLR_N);

	typedef struct packed {
		logic [TABLE_WAYS-1:0][TABLE_TAG_BITS-1:0] tag;
		logic [TABLE_WAYS-1:0][SECS-1:0]           vld;
		logic [TWB-1:0]                            ptr;
	} row_t;
	typedef logic [TABLE_WAYS-1:0][SECS-1:0][PC_INDEX_BITS-1:0] spc_t;
	typedef logic [CACHE_WAYS-1:0][1:0] rr_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_CAP,
		S_LOOK,
		S_CTR_RD,
		S_DEC,
		S_EVICT,
		S_BYP_RD,
		S_BYP,
		S_AGE,
		S_UPD,
		S_BUMP_RD,
		S_BUMP_WR
	} state_t;

	state_t               st_q;
	state_t               ret_q;
	logic [CLR_W-1:0]     clr_q;
	rdbs_pkg::cmd_t       cmd_q;
	row_t                 row_q;
	spc_t                 spc_q;
	rr_t                  rr_q;
	logic                 thit_q;
	logic [PC_INDEX_BITS-1:0] bpc_q;
	logic                 brs_q;
	logic [SECS-1:0]      evm_q;
	logic [SECS-1:0][PC_INDEX_BITS-1:0] evpc_q;
	logic [rdbs_pkg::MISS_W-1:0] mc_q;
	rdbs_pkg::rsp_t       res_q;
	logic                 rvalid_q;

	// decoded request fields
	logic [SET_W-1:0]          set_idx;
	logic [31:0]               line32;
	logic [1:0]                sec;
	logic [TABLE_SET_BITS-1:0] tset;
	logic [TABLE_TAG_BITS-1:0] tag;
	logic [PC_INDEX_BITS-1:0]  pc_idx;
	logic                      track;
	logic [CWI-1:0]            upd_w;

	assign set_idx = SET_W'(cmd_q.set_index);
	assign line32  = 32'(cmd_q.line_address);
	assign sec     = line32[1:0];
	assign tset    = TABLE_SET_BITS'(line32 >> rdbs_pkg::SECTOR_BITS);
	assign tag     = TABLE_TAG_BITS'(line32 >> TAG_SHIFT);
	assign pc_idx  = PC_INDEX_BITS'(32'(cmd_q.pc_low) >> rdbs_pkg::PC_SHIFT);
	assign track   = (tset[rdbs_pkg::TRACK_BITS-1:0] == '0);
	assign upd_w   = CWI'(cmd_q.way);

	// memory ports
	logic                      tbl_we;
	logic [TABLE_SET_BITS-1:0] tbl_waddr;
	row_t                      tbl_wdata;
	row_t                      tbl_rdata;
	logic                      spc_we;
	logic [SPC_AW-1:0]         spc_waddr;
	spc_t                      spc_wdata;
	spc_t                      spc_rdata;
	logic                      rr_we;
	logic [SET_W-1:0]          rr_waddr;
	rr_t                       rr_wdata;
	rr_t                       rr_rdata;
	logic                      ctr_we;
	logic [PC_INDEX_BITS-1:0]  ctr_waddr;
	logic [PC_INDEX_BITS-1:0]  ctr_raddr;
	rdbs_pkg::ctr_t            ctr_wdata;
	rdbs_pkg::ctr_t            ctr_rdata;

	rdbs_ram #(.WIDTH($bits(row_t)), .DEPTH(TSETS)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tset), .rdata(tbl_rdata)
	);
	rdbs_ram #(.WIDTH($bits(spc_t)), .DEPTH(SPC_DEPTH)) u_spc (
		.clk(clk), .we(spc_we), .waddr(spc_waddr), .wdata(spc_wdata),
		.raddr(tset[TABLE_SET_BITS-1:rdbs_pkg::TRACK_BITS]), .rdata(spc_rdata)
	);
	rdbs_ram #(.WIDTH($bits(rr_t)), .DEPTH(CACHE_SETS)) u_rr (
		.clk(clk), .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
		.raddr(set_idx), .rdata(rr_rdata)
	);
	rdbs_ram #(.WIDTH($bits(rdbs_pkg::ctr_t)), .DEPTH(NPCS)) u_ctr (
		.clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
		.raddr(ctr_raddr), .rdata(ctr_rdata)
	);

	// table search
	logic           hit_any;
	logic [TWB-1:0] hit_w;
	logic           tm_any;
	logic [TWB-1:0] tm_w;

	always_comb begin
		hit_any = 1'b0;
		hit_w   = '0;
		tm_any  = 1'b0;
		tm_w    = '0;
		for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
			if (row_q.tag[w] == tag) begin
				tm_any = 1'b1;
				tm_w   = TWB'(w);
				if (row_q.vld[w][sec]) begin
					hit_any = 1'b1;
					hit_w   = TWB'(w);
				end
			end
		end
	end

	// counter checks
	logic [CW+rdbs_pkg::REUSE_SHIFT-1:0] r64;
	logic [CW+1:0]  r3;
	logic           byp_cond;
	logic           remember;

	assign r64      = {ctr_rdata.reuse, rdbs_pkg::REUSE_SHIFT'(0)};
	assign r3       = {1'b0, ctr_rdata.reuse, 1'b0} + (CW+2)'(ctr_rdata.reuse);
	assign byp_cond = r3 < (CW+2)'(ctr_rdata.noreuse);
	assign remember = (r64 > $bits(r64)'(ctr_rdata.noreuse) && byp_cond) || (mc_q == '0);

	// counter bump with halving on overflow
	logic [CW:0]    r_inc;
	logic [CW:0]    n_inc;
	rdbs_pkg::ctr_t ctr_bump;

	always_comb begin
		r_inc = {1'b0, ctr_rdata.reuse} + (CW+1)'(brs_q);
		n_inc = {1'b0, ctr_rdata.noreuse} + (CW+1)'(!brs_q);
		if (r_inc[CW] || n_inc[CW]) begin
			ctr_bump.reuse   = r_inc[CW:1];
			ctr_bump.noreuse = n_inc[CW:1];
		end else begin
			ctr_bump.reuse   = r_inc[CW-1:0];
			ctr_bump.noreuse = n_inc[CW-1:0];
		end
	end

	// srrip aging and victim
	logic       any3;
	logic       any2;
	logic       any1;
	logic [1:0] age_add;
	rr_t        rr_aged;
	rr_t        rr_upd;
	logic [CWI-1:0] vic_w;

	always_comb begin
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int i = 0; i < CACHE_WAYS; i++) begin
			any3 = any3 | (rr_q[i] == 2'd3);
			any2 = any2 | (rr_q[i] == 2'd2);
			any1 = any1 | (rr_q[i] == 2'd1);
		end
		priority if (any3) age_add = 2'd0;
		else if (any2) age_add = 2'd1;
		else if (any1) age_add = 2'd2;
		else age_add = 2'd3;
		vic_w = '0;
		for (int i = CACHE_WAYS - 1; i >= 0; i--) begin
			rr_aged[i] = rr_q[i] + age_add;
			if (rr_aged[i] == rdbs_pkg::RRPV_MAX) begin
				vic_w = CWI'(i);
			end
		end
		rr_upd        = rr_q;
		rr_upd[upd_w] = cmd_q.hit ? rdbs_pkg::RRPV_HIT : rdbs_pkg::RRPV_FILL;
	end

	// row modifications
	row_t           row_mod;
	spc_t           spc_mod;
	logic [TWB-1:0] ptr_next;
	logic [1:0]     ev_s;

	assign ptr_next = (row_q.ptr == TWB'(TABLE_WAYS - 1)) ? '0 : row_q.ptr + 1'b1;

	always_comb begin
		row_mod = row_q;
		spc_mod = spc_q;
		if (st_q == S_LOOK) begin
			if (hit_any && track) begin
				row_mod.vld[hit_w][sec] = 1'b0;
			end
		end else if (tm_any) begin
			row_mod.vld[tm_w][sec] = 1'b1;
			spc_mod[tm_w][sec]     = pc_idx;
		end else begin
			row_mod.tag[row_q.ptr]      = tag;
			row_mod.vld[row_q.ptr]      = SECS'(1) << sec;
			row_mod.ptr                 = ptr_next;
			spc_mod[row_q.ptr][sec]     = pc_idx;
		end
		ev_s = '0;
		for (int s = SECS - 1; s >= 0; s--) begin
			if (evm_q[s]) begin
				ev_s = 2'(s);
			end
		end
	end

	// write side
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = tset;
		tbl_wdata = row_mod;
		spc_we    = 1'b0;
		spc_waddr = tset[TABLE_SET_BITS-1:rdbs_pkg::TRACK_BITS];
		spc_wdata = spc_mod;
		rr_we     = 1'b0;
		rr_waddr  = set_idx;
		rr_wdata  = rr_aged;
		ctr_we    = 1'b0;
		ctr_waddr = bpc_q;
		ctr_wdata = ctr_bump;
		ctr_raddr = (st_q == S_BUMP_RD) ? bpc_q : pc_idx;
		unique case (st_q)
			S_CLR: begin
				tbl_we            = 1'b1;
				tbl_waddr         = clr_q[TABLE_SET_BITS-1:0];
				tbl_wdata         = '0;
				spc_we            = 1'b1;
				spc_waddr         = clr_q[SPC_AW-1:0];
				spc_wdata         = '0;
				rr_we             = 1'b1;
				rr_waddr          = clr_q[SET_W-1:0];
				rr_wdata          = '1;
				ctr_we            = 1'b1;
				ctr_waddr         = clr_q[PC_INDEX_BITS-1:0];
				ctr_wdata.reuse   = rdbs_pkg::REUSE_INIT;
				ctr_wdata.noreuse = rdbs_pkg::NOREUSE_INIT;
			end
			S_LOOK: tbl_we = hit_any && track;
			S_DEC: begin
				tbl_we = remember;
				spc_we = remember && track;
			end
			S_AGE: rr_we = 1'b1;
			S_UPD: begin
				rr_we    = 1'b1;
				rr_wdata = rr_upd;
			end
			S_BUMP_WR: ctr_we = 1'b1;
			default: ;
		endcase
	end

	assign q_ready        = (st_q == S_IDLE) && (!rvalid_q || rsp.ready);
	assign init_done      = (st_q != S_CLR);
	assign rsp.valid      = rvalid_q;
	assign rsp.victim_way = res_q.victim_way;
	assign rsp.bypass     = res_q.bypass;
	assign rsp.table_hit  = res_q.table_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			clr_q    <= '0;
			rvalid_q <= 1'b0;
			mc_q     <= '0;
		end else begin
			if (rvalid_q && rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid && q_ready) begin
						cmd_q <= q_cmd;
						st_q  <= S_RD;
					end
				end
				S_RD: begin
					thit_q <= 1'b0;
					if (cmd_q.op == rdbs_pkg::OP_LOOKUP) begin
						mc_q <= mc_q + 1'b1;
					end
					st_q <= S_CAP;
				end
				S_CAP: begin
					row_q <= tbl_rdata;
					spc_q <= spc_rdata;
					rr_q  <= rr_rdata;
					unique case (cmd_q.op)
						rdbs_pkg::OP_LOOKUP: st_q <= S_LOOK;
						rdbs_pkg::OP_PLAIN:  st_q <= S_AGE;
						rdbs_pkg::OP_UPDATE: st_q <= S_UPD;
						rdbs_pkg::OP_IGNORE: begin
							res_q    <= '0;
							rvalid_q <= 1'b1;
							st_q     <= S_IDLE;
						end
					endcase
				end
				S_LOOK: begin
					thit_q <= hit_any;
					row_q  <= row_mod;
					if (hit_any && track) begin
						bpc_q <= spc_q[hit_w][sec];
						brs_q <= 1'b1;
						ret_q <= S_AGE;
						st_q  <= S_BUMP_RD;
					end else if (hit_any) begin
						st_q <= S_AGE;
					end else begin
						st_q <= S_CTR_RD;
					end
				end
				S_CTR_RD: st_q <= S_DEC;
				S_DEC: begin
					evm_q  <= (remember && !tm_any && track) ? row_q.vld[row_q.ptr] : '0;
					evpc_q <= spc_q[row_q.ptr];
					st_q   <= S_EVICT;
				end
				S_EVICT: begin
					if (evm_q != '0) begin
						bpc_q       <= evpc_q[ev_s];
						brs_q       <= 1'b0;
						evm_q[ev_s] <= 1'b0;
						ret_q       <= S_EVICT;
						st_q        <= S_BUMP_RD;
					end else begin
						st_q <= S_BYP_RD;
					end
				end
				S_BYP_RD: st_q <= S_BYP;
				S_BYP: begin
					if (byp_cond) begin
						res_q.victim_way <= rdbs_pkg::WAY_W'(CACHE_WAYS);
						res_q.bypass     <= 1'b1;
						res_q.table_hit  <= 1'b0;
						rvalid_q         <= 1'b1;
						st_q             <= S_IDLE;
					end else begin
						st_q <= S_AGE;
					end
				end
				S_AGE: begin
					res_q.victim_way <= rdbs_pkg::WAY_W'(vic_w);
					res_q.bypass     <= 1'b0;
					res_q.table_hit  <= thit_q;
					rvalid_q         <= 1'b1;
					st_q             <= S_IDLE;
				end
				S_UPD: begin
					res_q    <= '0;
					rvalid_q <= 1'b1;
					st_q     <= S_IDLE;
				end
				S_BUMP_RD: st_q <= S_BUMP_WR;
				S_BUMP_WR: st_q <= ret_q;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/rdbs_checker.sv =====
// port level checks of the replacement block and their binding
module rdbs_checker #(
	parameter int CW = rdbs_pkg::CACHE_WAYS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [rdbs_pkg::WAY_W-1:0]   victim_way,
	input logic                         bypass,
	input logic                         table_hit
);
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != '0)
		else $error("response without pending request");

	a_bypass_way: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bypass |-> victim_way == rdbs_pkg::WAY_W'(CW) && !table_hit)
		else $error("bypass with wrong way or table hit");

	a_way_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !bypass |-> {1'b0, victim_way} < 6'(CW))
		else $error("victim way out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({victim_way, bypass, table_hit}))
		else $error("stalled response changed");
endmodule

bind reuse_detector_bypass_srrip rdbs_checker #(.CW(CACHE_WAYS)) u_rdbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.victim_way (rsp.victim_way),
	.bypass     (rsp.bypass),
	.table_hit  (rsp.table_hit)
);

// ===== verif/tb_top.sv =====
// self-checking testbench of the reuse detector bypass replacement block
module tb_top;
	import rdbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// geometry of the predictor, taken from the package defaults
	localparam int TSETS       = 1 << TABLE_SET_BITS;
	localparam int NPCS        = 1 << PC_INDEX_BITS;
	localparam int CTR_MAX     = 1023;
	localparam int TRACK_EVERY = 1 << TRACK_BITS;
	localparam int PC_SLOTS    = (TSETS / TRACK_EVERY + 1) * TABLE_WAYS * SECTORS;
	localparam int N_RANDOM    = 1265;
	localparam int IDLE_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [SET_W-1:0]   set_index;
		logic [WAY_W-1:0]   way;
		logic [LINE_W-1:0]  line_address;
		logic [PCLOW_W-1:0] pc_low;
		kind_t              kind;
		logic               hit;
	} request_t;

	logic clk;
	logic arst_n;

	rdbs_req_if req_ch ();
	rdbs_rsp_if rsp_ch ();

	reuse_detector_bypass_srrip dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: reuse table, pc counters, miss counter and per-line rrpv
	logic [TABLE_TAG_BITS-1:0] tbl_tag   [TSETS*TABLE_WAYS];
	logic [SECTORS-1:0]        tbl_valid [TSETS*TABLE_WAYS];
	int unsigned               tbl_ptr   [TSETS];
	logic [PC_INDEX_BITS-1:0]  tbl_pc    [PC_SLOTS];
	int unsigned               reuse_ctr   [NPCS];
	int unsigned               noreuse_ctr [NPCS];
	logic [MISS_W-1:0]         miss_ctr;
	logic [1:0]                rrpv [CACHE_SETS*CACHE_WAYS];

	request_t pending_req_q[$];
	rsp_t     victim_forecast_q[$];

	int mismatches;
	int n_bypass;
	int n_table_hit;
	int n_responses;
	int idle_cycles;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int pc_slot(int tset, int w, int sec);
		return ((tset / TRACK_EVERY) * TABLE_WAYS + w) * SECTORS + sec;
	endfunction

	// raise one counter of a pc; halve both once either passes the ceiling
	function automatic void bump_pc(int pc, bit reused);
		int r;
		int n;
		r = reuse_ctr[pc];
		n = noreuse_ctr[pc];
		if (reused) r++; else n++;
		if (r > CTR_MAX || n > CTR_MAX) begin
			r = r >> 1;
			n = n >> 1;
		end
		reuse_ctr[pc]   = r;
		noreuse_ctr[pc] = n;
	endfunction

	function automatic bit probe_table(int tset, logic [TABLE_TAG_BITS-1:0] tag, int sec);
		int e;
		for (int w = 0; w < TABLE_WAYS; w++) begin
			e = tset * TABLE_WAYS + w;
			if (tbl_tag[e] == tag && tbl_valid[e][sec]) begin
				// tracked sets credit the pc that brought the sector in
				if (tset % TRACK_EVERY == 0) begin
					bump_pc(tbl_pc[pc_slot(tset, w, sec)], 1'b1);
					tbl_valid[e][sec] = 1'b0;
				end
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void remember_line(int tset, logic [TABLE_TAG_BITS-1:0] tag, int sec,
			int pc);
		int  w;
		int  e;
		bit  track;
		track = (tset % TRACK_EVERY == 0);
		for (w = 0; w < TABLE_WAYS; w++)
			if (tbl_tag[tset*TABLE_WAYS + w] == tag) break;
		if (w < TABLE_WAYS) begin
			// matching tag, valid or not: just add the sector
			e = tset * TABLE_WAYS + w;
			tbl_valid[e][sec] = 1'b1;
			if (track) tbl_pc[pc_slot(tset, w, sec)] = pc;
			return;
		end
		w = tbl_ptr[tset] % TABLE_WAYS;
		e = tset * TABLE_WAYS + w;
		// evicted live sectors count as no reuse for their pcs
		if (track)
			for (int s = 0; s < SECTORS; s++)
				if (tbl_valid[e][s]) bump_pc(tbl_pc[pc_slot(tset, w, s)], 1'b0);
		tbl_tag[e]   = tag;
		tbl_valid[e] = '0;
		tbl_valid[e][sec] = 1'b1;
		if (track) tbl_pc[pc_slot(tset, w, sec)] = pc;
		tbl_ptr[tset] = (w + 1) % TABLE_WAYS;
	endfunction

	function automatic rsp_t choose_victim(request_t rq);
		rsp_t res;
		int   set;
		int   base;
		int   sec;
		int   tset;
		int   pc;
		int   r;
		int   n;
		int   mx;
		bit   done;
		logic [TABLE_TAG_BITS-1:0] tag;
		res  = '0;
		done = 1'b0;
		set  = int'(rq.set_index) % CACHE_SETS;
		base = set * CACHE_WAYS;
		pc   = (int'(rq.pc_low) >> PC_SHIFT) & (NPCS - 1);
		if (rq.mode == MODE_UPDATE) begin
			if (rq.kind != KIND_WRITEBACK && rq.way < CACHE_WAYS)
				rrpv[base + rq.way] = rq.hit ? RRPV_HIT : RRPV_FILL;
			return res;
		end
		if (rq.kind != KIND_WRITEBACK) begin
			sec  = rq.line_address & (SECTORS - 1);
			tset = (rq.line_address >> SECTOR_BITS) & (TSETS - 1);
			tag  = rq.line_address >> (TABLE_SET_BITS + SECTOR_BITS);
			miss_ctr = miss_ctr + 1'b1;
			res.table_hit = probe_table(tset, tag, sec);
			if (!res.table_hit) begin
				r = reuse_ctr[pc];
				n = noreuse_ctr[pc];
				if ((r * 64 > n && r * 3 < n) || miss_ctr == '0)
					remember_line(tset, tag, sec, pc);
				if (reuse_ctr[pc] * 3 < noreuse_ctr[pc]) begin
					res.victim_way = CACHE_WAYS;
					res.bypass     = 1'b1;
					done           = 1'b1;
				end
			end
		end
		if (!done) begin
			// srrip: age the set until some way is distant, take the lowest one
			mx = 0;
			for (int i = 0; i < CACHE_WAYS; i++) if (rrpv[base+i] > mx) mx = rrpv[base+i];
			for (int i = 0; i < CACHE_WAYS; i++) rrpv[base+i] = rrpv[base+i] + (RRPV_MAX - mx);
			for (int i = 0; i < CACHE_WAYS; i++)
				if (rrpv[base+i] == RRPV_MAX) begin
					res.victim_way = i;
					break;
				end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic request_t mk_req(int mode, int set, int way, int line, int pcl,
			int kind, int hit);
		request_t rq;
		rq.mode         = mode;
		rq.set_index    = set;
		rq.way          = way;
		rq.line_address = line;
		rq.pc_low       = pcl;
		rq.kind         = kind_t'(kind);
		rq.hit          = hit;
		return rq;
	endfunction

	// hot address in a few table sets, tracked ones included, with few tags
	function automatic int hot_line();
		int tsets[5] = '{0, 4, 8, 1, 2};
		return (($urandom_range(0, 23)) << (TABLE_SET_BITS + SECTOR_BITS))
			| (tsets[$urandom_range(0, 4)] << SECTOR_BITS) | $urandom_range(0, 3);
	endfunction

	task automatic add_random();
		int set;
		int pcl;
		int k;
		if ($urandom_range(0, 9) < 7) begin
			// miss then fill of the same set, with the access flow of a real cache
			set = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 5);
			pcl = ($urandom_range(0, 7) << PC_SHIFT) | $urandom_range(0, 3);
			k   = $urandom_range(0, 9) == 0 ? int'(KIND_WRITEBACK) : $urandom_range(0, 2);
			pending_req_q.push_back(mk_req(MODE_VICTIM, set, $urandom_range(0, 31), hot_line(),
				pcl, k, $urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				pending_req_q.push_back(mk_req(MODE_UPDATE, set, $urandom_range(0, 15),
					hot_line(), pcl, $urandom_range(0, 2), $urandom_range(0, 1)));
		end else begin
			// noise over the whole field ranges
			pending_req_q.push_back(mk_req($urandom_range(0, 1), $urandom_range(0, 2047),
				$urandom_range(0, 31), $urandom_range(0, 524287), $urandom_range(0, 511),
				$urandom_range(0, 3), $urandom_range(0, 1)));
		end
	endtask

	initial begin
		// extremes of the fields and the load, rfo and prefetch kinds
		pending_req_q.push_back(mk_req(MODE_VICTIM, 0, 0, 0, 0, KIND_LOAD, 0));
		pending_req_q.push_back(mk_req(MODE_VICTIM, 2047, 31, 524287, 511, KIND_RFO, 1));
		pending_req_q.push_back(mk_req(MODE_VICTIM, 2047, 0, 524287, 511, KIND_PREFETCH, 0));
		// writeback victim request: plain srrip
		pending_req_q.push_back(mk_req(MODE_VICTIM, 5, 0, 100, 7, KIND_WRITEBACK, 0));
		// update hit, fill, writeback update, bypass way and beyond
		pending_req_q.push_back(mk_req(MODE_UPDATE, 0, 0, 0, 0, KIND_LOAD, 1));
		pending_req_q.push_back(mk_req(MODE_UPDATE, 0, 15, 0, 0, KIND_RFO, 0));
		pending_req_q.push_back(mk_req(MODE_UPDATE, 0, 1, 0, 0, KIND_WRITEBACK, 1));
		pending_req_q.push_back(mk_req(MODE_UPDATE, 0, 16, 0, 0, KIND_LOAD, 1));
		pending_req_q.push_back(mk_req(MODE_UPDATE, 2047, 31, 524287, 511, KIND_PREFETCH, 0));
		// repeated miss on a tracked table set: every eighth lookup remembers it,
		// the match on tag zero adds a sector, the next one hits and credits reuse
		for (int i = 0; i < 12; i++)
			pending_req_q.push_back(mk_req(MODE_VICTIM, 0, 0, 0, 4, KIND_LOAD, 0));
		pending_req_q.push_back(mk_req(MODE_VICTIM, 1, 0, 1, 8, KIND_PREFETCH, 0));
		for (int i = 0; i < N_RANDOM; i++) add_random();
	end

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		for (int i = 0; i < TSETS*TABLE_WAYS; i++) begin
			tbl_tag[i]   = '0;
			tbl_valid[i] = '0;
		end
		for (int i = 0; i < TSETS; i++) tbl_ptr[i] = 0;
		for (int i = 0; i < PC_SLOTS; i++) tbl_pc[i] = '0;
		for (int i = 0; i < NPCS; i++) begin
			reuse_ctr[i]   = REUSE_INIT;
			noreuse_ctr[i] = NOREUSE_INIT;
		end
		miss_ctr = '0;
		for (int i = 0; i < CACHE_SETS*CACHE_WAYS; i++) rrpv[i] = RRPV_MAX;
	end

	// ------------------------------------------------------------------
	// request driver: bursts of random length with random gaps
	// ------------------------------------------------------------------
	int burst_left;
	int gap_left;

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.mode         = '0;
		req_ch.set_index    = '0;
		req_ch.way          = '0;
		req_ch.line_address = '0;
		req_ch.pc_low       = '0;
		req_ch.access_kind  = '0;
		req_ch.hit          = 1'b0;
		burst_left          = 0;
		gap_left            = 0;
	end

	always @(posedge clk) begin
		request_t rq;
		bit       hold;
		bit       nv;
		if (arst_n) begin
			hold = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				// accepted request: predict its response now
				victim_forecast_q.push_back(choose_victim(pending_req_q[0]));
				void'(pending_req_q.pop_front());
				if (burst_left > 0) burst_left--;
				hold = 1'b0;
			end
			nv = hold;
			if (!hold) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = $urandom_range(0, 5) == 0 ? $urandom_range(0, 40)
						: $urandom_range(0, 4);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_req_q.size() > 0) begin
					nv = 1'b1;
				end
			end
			if (nv && !hold) begin
				rq = pending_req_q[0];
				req_ch.mode         <= rq.mode;
				req_ch.set_index    <= rq.set_index;
				req_ch.way          <= rq.way;
				req_ch.line_address <= rq.line_address;
				req_ch.pc_low       <= rq.pc_low;
				req_ch.access_kind  <= rq.kind;
				req_ch.hit          <= rq.hit;
			end
			req_ch.valid <= nv;
		end
	end

	// ------------------------------------------------------------------
	// response monitor with its own stall pattern
	// ------------------------------------------------------------------
	logic [15:0] stall_pat;
	int          pat_age;

	initial begin
		rsp_ch.ready = 1'b0;
		stall_pat    = 16'hffff;
		pat_age      = 0;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d (response %0d)", what, got, want,
			n_responses);
		mismatches++;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (victim_forecast_q.size() == 0) begin
					report_mismatch("unexpected response", 1, 0);
				end else begin
					want = victim_forecast_q.pop_front();
					if (rsp_ch.victim_way !== want.victim_way)
						report_mismatch("victim_way", rsp_ch.victim_way, want.victim_way);
					if (rsp_ch.bypass !== want.bypass)
						report_mismatch("bypass", rsp_ch.bypass, want.bypass);
					if (rsp_ch.table_hit !== want.table_hit)
						report_mismatch("table_hit", rsp_ch.table_hit, want.table_hit);
					if (want.bypass) n_bypass++;
					if (want.table_hit) n_table_hit++;
				end
				n_responses++;
			end
			// new pattern now and then, sometimes a stretch with no stalls
			pat_age++;
			if (pat_age == 64) begin
				pat_age   = 0;
				stall_pat = $urandom_range(0, 2) == 0 ? 16'hffff : 16'($urandom);
			end else begin
				stall_pat = {stall_pat[14:0], stall_pat[15]};
			end
			rsp_ch.ready <= stall_pat[0];
		end
	end

	// ------------------------------------------------------------------
	// watchdog and end of run
	// ------------------------------------------------------------------
	initial begin
		mismatches  = 0;
		n_bypass    = 0;
		n_table_hit = 0;
		n_responses = 0;
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no request or response moved for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (pending_req_q.size() == 0 && victim_forecast_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d responses: %0d bypassed, %0d table hits", n_responses, n_bypass,
			n_table_hit);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && victim_forecast_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
